// ===== sv/hwmb_pkg.sv =====
// shared types, codes and widths for the histogram with tracked mode bin
// no dependencies
`timescale 1ns / 1ps

package hwmb_pkg;

   localparam int DATA_W       = 32;
   localparam int BW_W         = 31;
   localparam int KIND_W       = 2;
   localparam int SEL_W        = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int NUM_BINS_DEF = 256;
   localparam int DIV_STEPS    = 32;
   localparam int DIV_CNT_W    = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEST   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_WIDTH = 2'd2;

   localparam logic [DATA_W-1:0] RANGE_MIN_RST = 32'h0000_0000;
   localparam logic [DATA_W-1:0] RANGE_MAX_RST = 32'h0001_0000;
   localparam logic [BW_W-1:0]   BIN_WIDTH_RST = 31'h0001_0000;

   // controller to datapath
   typedef struct packed {
      logic clr_step;
      logic take_item;
      logic div_biu;
      logic div_item;
      logic biu_load;
      logic rd_issue;
      logic finish;
   } hwmb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic div_done;
      logic need_div;
      logic is_read;
      logic out_free;
   } hwmb_sts_type;

   function automatic logic csr_hit(input logic we, input logic [CSR_IDX_W-1:0] idx);
      csr_hit = we && (idx == REG_RANGE_MIN || idx == REG_RANGE_MAX || idx == REG_BIN_WIDTH);
   endfunction

endpackage

// ===== sv/hwmb_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit dividend by 31-bit divisor
// depends on hwmb_pkg
`timescale 1ns / 1ps

module hwmb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hwmb_pkg::DATA_W-1:0]  dividend,
   input  logic [hwmb_pkg::BW_W-1:0]    divisor,
   output logic [hwmb_pkg::DATA_W-1:0]  quotient,
   output logic                         done
);
   import hwmb_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    dvd_ff, dvd_in;
   logic [BW_W-1:0]      dsr_ff, dsr_in;
   logic [BW_W-1:0]      rem_ff, rem_in;
   logic [DATA_W-1:0]    trial;
   logic [DATA_W-1:0]    trial_sub;
   logic                 q_bit;

   // remainder stays below the divisor, so the shifted trial fits in 32 bits
   assign trial     = {rem_ff, dvd_ff[DATA_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign q_bit     = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DATA_W-2:0], q_bit};
         rem_in = q_bit ? trial_sub[BW_W-1:0] : trial[BW_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;

endmodule

// ===== sv/hwmb_dp.sv =====
// datapath: config registers, bin count memory, divider, mode tracking, result register
// depends on hwmb_pkg and hwmb_div
`timescale 1ns / 1ps

module hwmb_dp #(
   parameter int NUM_BINS = hwmb_pkg::NUM_BINS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hwmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hwmb_pkg::DATA_W-1:0]     csr_wdata,
   input  logic [hwmb_pkg::KIND_W-1:0]     req_kind,
   input  logic signed [hwmb_pkg::DATA_W-1:0] req_sample,
   input  logic [hwmb_pkg::SEL_W-1:0]      req_bin_select,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_ok,
   output logic [hwmb_pkg::DATA_W-1:0]     rsp_bin_count,
   output logic [hwmb_pkg::SEL_W-1:0]      rsp_bin_hit,
   output logic [hwmb_pkg::SEL_W-1:0]      rsp_mode_bin,
   input  hwmb_pkg::hwmb_cmd_type          cmd,
   output hwmb_pkg::hwmb_sts_type          sts
);
   import hwmb_pkg::*;

   localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CNT_W = $clog2(NUM_BINS + 1);

   logic signed [DATA_W-1:0] range_min_ff, range_max_ff;
   logic [BW_W-1:0]          bin_width_ff;
   logic [CNT_W-1:0]         biu_ff;
   logic [IDX_W-1:0]         mode_idx_ff;
   logic [DATA_W-1:0]        mode_cnt_ff;
   logic [IDX_W-1:0]         ptr_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic signed [DATA_W-1:0] sample_ff;
   logic [SEL_W-1:0]         sel_ff;
   logic [DATA_W-1:0]        rd_data_ff;
   logic                     rsp_valid_ff;
   logic                     ok_ff;
   logic [DATA_W-1:0]        count_ff;
   logic [SEL_W-1:0]         hit_ff;
   logic [SEL_W-1:0]         mode_out_ff;

   logic [DATA_W-1:0] mem [NUM_BINS];

   logic              cfg_wr;
   logic              sweep_last;
   logic              in_range;
   logic              range_ok;
   logic [DATA_W-1:0] div_dividend;
   logic [DATA_W-1:0] quo;
   logic              div_done;
   logic [DATA_W-1:0] biu_wide;
   logic              loc_ok;
   logic [IDX_W-1:0]  idx;
   logic [DATA_W-1:0] sel_wide;
   logic              sel_ok;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] c_new;
   logic              mode_upd;
   logic [IDX_W-1:0]  mode_idx_in;
   logic [DATA_W-1:0] mode_idx_wide;
   logic              ok_in;
   logic [DATA_W-1:0] count_in;
   logic [SEL_W-1:0]  hit_in;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              out_free;

   assign cfg_wr     = csr_hit(csr_we, csr_index);
   assign sweep_last = (ptr_ff == IDX_W'(NUM_BINS - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign in_range = (sample_ff > range_min_ff) && (sample_ff < range_max_ff);
   assign range_ok = (range_max_ff > range_min_ff) && (bin_width_ff != '0);

   // differences are below 2^32 whenever they are used, so 32 bits suffice
   assign div_dividend = cmd.div_biu ? DATA_W'(range_max_ff - range_min_ff)
                                     : DATA_W'(sample_ff - range_min_ff);

   hwmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_biu || cmd.div_item),
      .dividend (div_dividend),
      .divisor  (bin_width_ff),
      .quotient (quo),
      .done     (div_done)
   );

   assign sts.sweep_last = sweep_last;
   assign sts.div_done   = div_done;
   assign sts.need_div   = (kind_ff == KIND_INSERT || kind_ff == KIND_TEST)
                           && in_range && (bin_width_ff != '0);
   assign sts.is_read    = (kind_ff == KIND_READ);
   assign sts.out_free   = out_free;

   assign biu_wide = DATA_W'(biu_ff);
   assign loc_ok   = sts.need_div && (quo < biu_wide);
   assign idx      = quo[IDX_W-1:0];
   assign sel_wide = DATA_W'(sel_ff);
   assign sel_ok   = (sel_wide < biu_wide) && (sel_wide < DATA_W'(NUM_BINS));
   assign rd_addr  = sts.is_read ? sel_wide[IDX_W-1:0] : idx;

   // saturating increment and lowest-index tie break
   assign c_new    = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
   assign mode_upd = (kind_ff == KIND_INSERT) && loc_ok &&
                     ((c_new > mode_cnt_ff) || (c_new == mode_cnt_ff && idx < mode_idx_ff));
   assign mode_idx_in   = mode_upd ? idx : mode_idx_ff;
   assign mode_idx_wide = DATA_W'(mode_idx_in);

   always_comb begin
      ok_in    = 1'b0;
      count_in = '0;
      hit_in   = '0;
      case (kind_ff)
         KIND_INSERT: begin
            if (loc_ok) begin
               ok_in    = 1'b1;
               count_in = c_new;
               hit_in   = quo[SEL_W-1:0];
            end
         end
         KIND_TEST: begin
            if (loc_ok) begin
               ok_in    = (idx == mode_idx_ff);
               count_in = rd_data_ff;
               hit_in   = quo[SEL_W-1:0];
            end
         end
         KIND_READ: begin
            if (sel_ok) begin
               ok_in    = 1'b1;
               count_in = rd_data_ff;
               hit_in   = sel_ff;
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = '0;
      if (cmd.clr_step) begin
         mem_we = 1'b1;
      end else if (cmd.finish && kind_ff == KIND_INSERT && loc_ok) begin
         mem_we    = 1'b1;
         mem_waddr = idx;
         mem_wdata = c_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= RANGE_MIN_RST;
         range_max_ff <= RANGE_MAX_RST;
         bin_width_ff <= BIN_WIDTH_RST;
         biu_ff       <= CNT_W'(1);
         mode_idx_ff  <= '0;
         mode_cnt_ff  <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_index)
               REG_RANGE_MIN: range_min_ff <= csr_wdata;
               REG_RANGE_MAX: range_max_ff <= csr_wdata;
               REG_BIN_WIDTH: bin_width_ff <= csr_wdata[BW_W-1:0];
               default:       range_min_ff <= range_min_ff;
            endcase
            mode_idx_ff <= '0;
            mode_cnt_ff <= '0;
            ptr_ff      <= '0;
         end else if (cmd.clr_step) begin
            ptr_ff <= sweep_last ? '0 : ptr_ff + 1'b1;
         end
         if (cmd.biu_load) begin
            if (!range_ok) begin
               biu_ff <= '0;
            end else if (quo > DATA_W'(NUM_BINS)) begin
               biu_ff <= CNT_W'(NUM_BINS);
            end else begin
               biu_ff <= quo[CNT_W-1:0];
            end
         end
         if (cmd.finish && mode_upd) begin
            mode_idx_ff <= idx;
            mode_cnt_ff <= c_new;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         kind_ff   <= req_kind;
         sample_ff <= req_sample;
         sel_ff    <= req_bin_select;
      end
      if (cmd.finish) begin
         ok_ff       <= ok_in;
         count_ff    <= count_in;
         hit_ff      <= hit_in;
         mode_out_ff <= mode_idx_wide[SEL_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_bin_count = count_ff;
   assign rsp_bin_hit   = hit_ff;
   assign rsp_mode_bin  = mode_out_ff;

   // a nonzero mode count always points at a bin in use
   a_mode_in_use: assert property (@(posedge clock) disable iff (reset)
      (mode_cnt_ff != '0) |-> (DATA_W'(mode_idx_ff) < biu_wide))
      else $error("mode bin outside bins in use");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result overwritten while still held");

   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result beat without a finished item");

endmodule

// ===== sv/hwmb_ctrl.sv =====
// controller: clearing sweep, bin count setup, per-item sequencing
// depends on hwmb_pkg
`timescale 1ns / 1ps

module hwmb_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hwmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hwmb_pkg::hwmb_sts_type          sts,
   output hwmb_pkg::hwmb_cmd_type          cmd
);
   import hwmb_pkg::*;

   localparam logic [2:0] ST_CLR      = 3'd0;
   localparam logic [2:0] ST_BIU      = 3'd1;
   localparam logic [2:0] ST_BIU_WAIT = 3'd2;
   localparam logic [2:0] ST_IDLE     = 3'd3;
   localparam logic [2:0] ST_PREP     = 3'd4;
   localparam logic [2:0] ST_DIV      = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;
   localparam logic [2:0] ST_FIN      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       cfg_wr;

   assign cfg_wr    = csr_hit(csr_we, csr_index);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.sweep_last) state_in = ST_BIU;
         end
         ST_BIU: begin
            cmd.div_biu = 1'b1;
            state_in    = ST_BIU_WAIT;
         end
         ST_BIU_WAIT: begin
            if (sts.div_done) begin
               cmd.biu_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sts.need_div) begin
               cmd.div_item = 1'b1;
               state_in     = ST_DIV;
            end else if (sts.is_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLR;
      endcase
      // any register write restarts the sweep
      if (cfg_wr) state_in = ST_CLR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (state_ff == ST_CLR))
      else $error("register write did not restart the clear");

   a_read_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_DIV || $past(state_ff) == ST_PREP))
      else $error("memory read entered out of sequence");

   a_fin_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && $past(state_ff) != ST_FIN)
      |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_PREP))
      else $error("finish entered out of sequence");

endmodule

// ===== sv/histogram_with_mode_bin.sv =====
// top level of the fixed-bin histogram with tracked mode bin
// depends on hwmb_pkg, hwmb_ctrl, hwmb_dp, hwmb_div
//
// usage:
//   req_* beats carry an operation kind (insert, test against mode bin, read count),
//   a Q16.16 sample and a bin index; each beat gives exactly one rsp_* beat
//   csr_we writes range_min, range_max or bin_width; any such write clears the
//   bin counts and the mode bin and recomputes the number of bins in use
// sequence of an item:
//   insert and test of an in-range sample go from accept to result via a setup
//   step, the bit-serial divider, one memory read and a final step that loads
//   the result (insert also writes the count back); reads skip the divider and
//   other items skip the read as well; one item is in work at a time and the next
//   beat is accepted the cycle after the result is loaded; the divider sets the pace
// reset and config writes:
//   the block sweeps the count memory, one bin a cycle, then runs the divider
//   once for the bin count, with req_ready low throughout
// stalls:
//   the result sits in an output register; a new beat is accepted while it
//   waits, and that item holds in its last step until rsp_ready frees the register
`timescale 1ns / 1ps

module histogram_with_mode_bin #(
   parameter int NUM_BINS = hwmb_pkg::NUM_BINS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [hwmb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hwmb_pkg::DATA_W-1:0]        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hwmb_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [hwmb_pkg::DATA_W-1:0] req_sample,
   input  logic [hwmb_pkg::SEL_W-1:0]         req_bin_select,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic [hwmb_pkg::DATA_W-1:0]        rsp_bin_count,
   output logic [hwmb_pkg::SEL_W-1:0]         rsp_bin_hit,
   output logic [hwmb_pkg::SEL_W-1:0]         rsp_mode_bin
);
   import hwmb_pkg::*;

   hwmb_cmd_type cmd;
   hwmb_sts_type sts;

   hwmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hwmb_dp #(
      .NUM_BINS (NUM_BINS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_bin_select (req_bin_select),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_bin_count  (rsp_bin_count),
      .rsp_bin_hit    (rsp_bin_hit),
      .rsp_mode_bin   (rsp_mode_bin),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

// ===== test/hwmb_histogram_check.sv =====
// checker for the histogram with tracked mode bin: watches the csr port and both
// channels, predicts every rsp beat and compares it field by field
// depends on hwmb_pkg
`timescale 1ns / 1ps

module hwmb_histogram_check #(
   parameter int NUM_BINS = hwmb_pkg::NUM_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hwmb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hwmb_pkg::DATA_W-1:0]         csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [hwmb_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [hwmb_pkg::DATA_W-1:0]  req_sample,
   input  logic [hwmb_pkg::SEL_W-1:0]          req_bin_select,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_ok,
   input  logic [hwmb_pkg::DATA_W-1:0]         rsp_bin_count,
   input  logic [hwmb_pkg::SEL_W-1:0]          rsp_bin_hit,
   input  logic [hwmb_pkg::SEL_W-1:0]          rsp_mode_bin,
   output int                                  pending,
   output int                                  mismatches
);
   import hwmb_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] count;
      logic [SEL_W-1:0]  hit;
      logic [SEL_W-1:0]  mode;
   } hist_rsp_type;

   logic signed [DATA_W-1:0] lo_q;
   logic signed [DATA_W-1:0] hi_q;
   logic [BW_W-1:0]          width_q;
   logic [DATA_W-1:0]        counts [NUM_BINS];
   logic [SEL_W-1:0]         mode_idx;
   logic [DATA_W-1:0]        mode_cnt;
   int unsigned              bins_used;
   hist_rsp_type             rsp_due [$];

   function automatic void clear_hist();
      longint span;
      longint nbins;
      foreach (counts[i]) counts[i] = '0;
      mode_idx  = '0;
      mode_cnt  = '0;
      bins_used = 0;
      span = longint'(hi_q) - longint'(lo_q);
      if (span > 0 && width_q != '0) begin
         nbins = span / longint'({1'b0, width_q});
         bins_used = (nbins > NUM_BINS) ? NUM_BINS : int'(nbins);
      end
   endfunction

   // bin of a sample, or 0 when it is outside the range, past the last full bin or the width is zero
   function automatic bit bin_of_sample(input logic signed [DATA_W-1:0] s,
                                        output logic [SEL_W-1:0] idx);
      longint q;
      idx = '0;
      if (!(s > lo_q && s < hi_q) || width_q == '0) return 1'b0;
      q = (longint'(s) - longint'(lo_q)) / longint'({1'b0, width_q});
      if (q >= longint'(bins_used)) return 1'b0;
      idx = q[SEL_W-1:0];
      return 1'b1;
   endfunction

   function automatic hist_rsp_type apply_op(input logic [KIND_W-1:0] kind,
                                             input logic signed [DATA_W-1:0] s,
                                             input logic [SEL_W-1:0] sel);
      hist_rsp_type      r;
      logic [SEL_W-1:0]  idx;
      logic [DATA_W-1:0] c;
      r = '0;
      case (kind)
         KIND_INSERT: begin
            if (bin_of_sample(s, idx)) begin
               c = counts[idx];
               if (c != '1) c = c + 1'b1;
               counts[idx] = c;
               if (c > mode_cnt || (c == mode_cnt && idx < mode_idx)) begin
                  mode_cnt = c;
                  mode_idx = idx;
               end
               r.ok    = 1'b1;
               r.count = c;
               r.hit   = idx;
            end
         end
         KIND_TEST: begin
            if (bin_of_sample(s, idx)) begin
               r.ok    = (idx == mode_idx);
               r.count = counts[idx];
               r.hit   = idx;
            end
         end
         KIND_READ: begin
            if (sel < bins_used) begin
               r.ok    = 1'b1;
               r.count = counts[sel];
               r.hit   = sel;
            end
         end
         default: ;
      endcase
      r.mode = mode_idx;
      return r;
   endfunction

   always @(posedge clock) begin
      hist_rsp_type want;
      hist_rsp_type got;
      if (reset) begin
         lo_q       = RANGE_MIN_RST;
         hi_q       = RANGE_MAX_RST;
         width_q    = BIN_WIDTH_RST;
         mismatches = 0;
         clear_hist();
         rsp_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_RANGE_MIN: begin
                  lo_q = csr_wdata;
                  clear_hist();
               end
               REG_RANGE_MAX: begin
                  hi_q = csr_wdata;
                  clear_hist();
               end
               REG_BIN_WIDTH: begin
                  width_q = csr_wdata[BW_W-1:0];
                  clear_hist();
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.ok    = rsp_ok;
            got.count = rsp_bin_count;
            got.hit   = rsp_bin_hit;
            got.mode  = rsp_mode_bin;
            if (rsp_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: extra rsp beat: ok %0d count %0d hit %0d mode %0d",
                           $realtime, got.ok, got.count, got.hit, got.mode);
            end else begin
               want = rsp_due.pop_front();
               if (got.ok !== want.ok || got.count !== want.count ||
                   got.hit !== want.hit || got.mode !== want.mode) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: rsp mismatch exp ok %0d count %0d hit %0d mode %0d",
                              $realtime, want.ok, want.count, want.hit, want.mode);
                     $display("%t:              got ok %0d count %0d hit %0d mode %0d",
                              $realtime, got.ok, got.count, got.hit, got.mode);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            rsp_due = {rsp_due, apply_op(req_kind, req_sample, req_bin_select)};
      end
      pending = rsp_due.size();
   end

endmodule

// ===== test/tb_histogram_with_mode_bin.sv =====
// testbench top for histogram_with_mode_bin: clock, reset, csr writes, req stimulus
// and rsp backpressure; checking lives in hwmb_histogram_check
// depends on hwmb_pkg, hwmb_histogram_check and the block itself
`timescale 1ns / 1ps

module tb_histogram_with_mode_bin;
   import hwmb_pkg::*;

   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int ONE = 65536;
   localparam logic [BW_W-1:0] ONE_BW = 31'h0001_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [DATA_W-1:0]         csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [KIND_W-1:0]         req_kind = '0;
   logic signed [DATA_W-1:0]  req_sample = '0;
   logic [SEL_W-1:0]          req_bin_select = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_ok;
   logic [DATA_W-1:0]         rsp_bin_count;
   logic [SEL_W-1:0]          rsp_bin_hit;
   logic [SEL_W-1:0]          rsp_mode_bin;
   int                        pending;
   int                        mismatches;
   bit                        steady = 1'b0;
   int                        quiet_cycles = 0;

   histogram_with_mode_bin u_dut (.*);
   hwmb_histogram_check u_check (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= (reset || steady) ? 1'b1 : ($urandom_range(0, 99) >= 38);

   // no beat on either channel for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] s,
                            input logic [SEL_W-1:0] sel);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_sample     <= s;
      req_bin_select <= sel;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic load_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                             input logic [BW_W-1:0] width);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= REG_RANGE_MIN;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= REG_RANGE_MAX;
      csr_wdata <= hi;
      @(posedge clock);
      // top bit is not part of the register
      csr_index <= REG_BIN_WIDTH;
      csr_wdata <= {1'($urandom_range(0, 1)), width};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // a legal sample, often packed into the first four bins so counts pile up unevenly
   function automatic logic [DATA_W-1:0] in_range_sample(input logic signed [DATA_W-1:0] lo,
                                                         input logic signed [DATA_W-1:0] hi,
                                                         input logic [BW_W-1:0] width);
      longint unsigned room;
      longint unsigned off;
      longint unsigned near;
      room = longint'(hi) - longint'(lo) - 1;
      off  = {$urandom, $urandom} % room;
      near = 4 * longint'({1'b0, width});
      if ($urandom_range(0, 1) == 1 && near != 0 && near < room) off = off % near;
      return DATA_W'(longint'(lo) + 1 + longint'(off));
   endfunction

   task automatic random_items(input logic signed [DATA_W-1:0] lo,
                               input logic signed [DATA_W-1:0] hi,
                               input logic [BW_W-1:0] width, input int n);
      int                pick;
      bit                legal;
      logic [DATA_W-1:0] s;
      logic [SEL_W-1:0]  sel;
      legal = (longint'(hi) - longint'(lo) >= 2);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         sel  = SEL_W'($urandom);
         s    = legal ? in_range_sample(lo, hi, width) : DATA_W'($urandom);
         if (pick < 48) begin
            send_item(KIND_INSERT, s, sel);
         end else if (pick < 63) begin
            send_item(KIND_TEST, s, sel);
         end else if (pick < 78) begin
            send_item(KIND_READ, DATA_W'($urandom), SEL_W'($urandom_range(0, 20)));
         end else if (pick < 86) begin
            send_item(KIND_READ, DATA_W'($urandom), sel);
         end else if (pick < 94) begin
            // range edges and wild samples
            case ($urandom_range(0, 4))
               0: s = lo;
               1: s = hi;
               2: s = lo + 1;
               3: s = hi - 1;
               default: s = DATA_W'($urandom);
            endcase
            send_item($urandom_range(0, 1) ? KIND_TEST : KIND_INSERT, s, sel);
         end else begin
            send_item(KIND_NOP, DATA_W'($urandom), sel);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset setting: one bin covering (0, 1.0)
      send_item(KIND_READ, 32'h0, 8'd0);
      send_item(KIND_TEST, 32'h1, 8'd0);
      send_item(KIND_INSERT, 32'h0, 8'd0);
      send_item(KIND_INSERT, ONE, 8'd0);
      send_item(KIND_INSERT, 32'h1, 8'hff);
      send_item(KIND_INSERT, 32'h0000_ffff, 8'd0);
      send_item(KIND_INSERT, 32'h8000_0000, 8'd0);
      send_item(KIND_INSERT, 32'h7fff_ffff, 8'd0);
      send_item(KIND_TEST, 32'h7fff_ffff, 8'd0);
      send_item(KIND_READ, 32'hffff_ffff, 8'd1);
      send_item(KIND_READ, 32'h0, 8'hff);
      send_item(KIND_NOP, 32'hffff_ffff, 8'hff);
      send_item(KIND_TEST, 32'h0000_8000, 8'd0);

      // sixteen bins over (-8, 8); tie on the count moves the mode to the lower bin
      load_range(-8 * ONE, 8 * ONE, ONE_BW);
      send_item(KIND_INSERT, -8 * ONE + 3 * ONE + 100, 8'd0);
      send_item(KIND_INSERT, -8 * ONE + 3 * ONE + 200, 8'd0);
      send_item(KIND_INSERT, -8 * ONE + 1 * ONE + 100, 8'd0);
      send_item(KIND_INSERT, -8 * ONE + 1 * ONE + 300, 8'd0);
      send_item(KIND_TEST, -8 * ONE + 3 * ONE + 5, 8'd0);
      send_item(KIND_TEST, -8 * ONE + 1 * ONE + 5, 8'd0);
      send_item(KIND_READ, 32'h0, 8'd3);
      steady = 1'b1;
      random_items(-8 * ONE, 8 * ONE, ONE_BW, 100);
      steady = 1'b0;
      wait_drained();
      random_items(-8 * ONE, 8 * ONE, ONE_BW, 50);

      // partial top bin is never used
      load_range(0, 3 * ONE + ONE / 2, ONE_BW);
      random_items(0, 3 * ONE + ONE / 2, ONE_BW, 90);

      // exactly the full set of bins
      load_range(-ONE / 2, ONE / 2, 31'd256);
      random_items(-ONE / 2, ONE / 2, 31'd256, 120);

      // full span at the finest width, capped to the bin store
      load_range(32'h8000_0000, 32'h7fff_ffff, 31'd1);
      random_items(32'sh8000_0000, 32'sh7fff_ffff, 31'd1, 80);

      // full span at the widest bin
      load_range(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
      random_items(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 60);

      // empty range, then zero width: no item ever gets an ok result
      load_range(ONE, ONE, ONE_BW);
      random_items(ONE, ONE, ONE_BW, 40);
      load_range(-4 * ONE, 4 * ONE, 31'd0);
      random_items(-4 * ONE, 4 * ONE, 31'd0, 40);

      // three odd-width bins
      load_range(0, 10 * ONE, 31'h0003_0001);
      random_items(0, 10 * ONE, 31'h0003_0001, 120);

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hwmb_pkg.sv
sv/hwmb_div.sv
sv/hwmb_dp.sv
sv/hwmb_ctrl.sv
sv/histogram_with_mode_bin.sv
test/hwmb_histogram_check.sv
test/tb_histogram_with_mode_bin.sv
